@@ design/i2c_master_register_access_top_macros.svh @@
// assertion helpers for the i2c register access master
`ifndef I2C_MASTER_REGISTER_ACCESS_TOP_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_TOP_MACROS_SVH

// clocked assertion, quiet while reset is high
`define I2CM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked implication, quiet while reset is high
`define I2CM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/i2cm_pkg.sv @@
`default_nettype none
package i2cm_pkg;

  localparam int MAX_BURST_DEF = 16;
  localparam logic [3:0] RETRY_RESET = 4'd5;
  localparam logic [7:0] ACK_WAIT_RESET = 8'd20;

  // command kinds
  localparam logic [1:0] REQ_IDLE  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // completion codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RETRY     = 3'd1;
  localparam logic [2:0] ST_REG_NACK  = 3'd2;
  localparam logic [2:0] ST_DATA_NACK = 3'd3;
  localparam logic [2:0] ST_RADR_NACK = 3'd4;

  // config register indexes
  localparam logic REG_RETRY = 1'b0;
  localparam logic REG_WAIT  = 1'b1;

  // one tick result
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage
`default_nettype wire

@@ design/i2cm_wbuf.sv @@
`default_nettype none
module i2cm_wbuf import i2cm_pkg::*; #(
  parameter int MAX_BURST = MAX_BURST_DEF,
  localparam int AW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [MAX_BURST];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ design/i2cm_engine.sv @@
`default_nettype none
module i2cm_engine import i2cm_pkg::*; #(
  parameter int MAX_BURST = MAX_BURST_DEF,
  localparam int AW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1,
  localparam int CW = $clog2(MAX_BURST + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [1:0]    req_type,
  input  wire logic [7:0]    dev_addr,
  input  wire logic [7:0]    reg_addr,
  input  wire logic [4:0]    byte_count,
  input  wire logic          sda_in,
  input  wire logic [3:0]    addr_retry_limit,
  input  wire logic [7:0]    ack_wait_limit,
  input  wire logic [7:0]    buf_rd_data,
  output logic               buf_wr_en,
  output logic      [AW-1:0] buf_wr_addr,
  output logic      [AW-1:0] buf_rd_addr,
  output res_t               res
);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_ADDR_STOP  = 4'd1;
  localparam logic [3:0] PH_ADDR_START = 4'd2;
  localparam logic [3:0] PH_ADDR_BYTE  = 4'd3;
  localparam logic [3:0] PH_ADDR_ACK   = 4'd4;
  localparam logic [3:0] PH_REG_BYTE   = 4'd5;
  localparam logic [3:0] PH_REG_ACK    = 4'd6;
  localparam logic [3:0] PH_RS_START   = 4'd7;
  localparam logic [3:0] PH_RADDR_BYTE = 4'd8;
  localparam logic [3:0] PH_RADDR_ACK  = 4'd9;
  localparam logic [3:0] PH_WDATA_BYTE = 4'd10;
  localparam logic [3:0] PH_WDATA_ACK  = 4'd11;
  localparam logic [3:0] PH_RDATA_BYTE = 4'd12;
  localparam logic [3:0] PH_RDATA_ACK  = 4'd13;
  localparam logic [3:0] PH_END_STOP   = 4'd14;

  localparam logic [2:0] SEG_NONE  = 3'd0;
  localparam logic [2:0] SEG_STOP  = 3'd1;
  localparam logic [2:0] SEG_START = 3'd2;
  localparam logic [2:0] SEG_WBYTE = 3'd3;
  localparam logic [2:0] SEG_RBYTE = 3'd4;
  localparam logic [2:0] SEG_RACK  = 3'd5;
  localparam logic [2:0] SEG_WACK  = 3'd6;

  logic [3:0]    phase, phase_next;
  logic [2:0]    micro, micro_next;
  logic [3:0]    bit_counter, bit_counter_next;
  logic [CW-1:0] byte_index, byte_index_next;
  logic [3:0]    retry_counter, retry_counter_next;
  logic [7:0]    wait_counter, wait_counter_next;
  logic [7:0]    shift_reg, shift_reg_next;
  logic [7:0]    held_dev_addr, held_dev_addr_next;
  logic [7:0]    held_reg_addr, held_reg_addr_next;
  logic [CW-1:0] held_count, held_count_next;
  logic          read_mode, read_mode_next;
  logic [CW-1:0] load_pointer, load_pointer_next;
  logic          nack_flag, nack_flag_next;
  logic          pin_scl, pin_scl_next;
  logic          pin_sda, pin_sda_next;
  logic          pin_oe, pin_oe_next;

  logic [2:0]    seg;
  logic          seg_done;
  logic [3:0]    bc_inc;
  logic [CW-1:0] bi_inc;
  logic          ack_level;

  assign bc_inc = bit_counter + 4'd1;
  assign bi_inc = byte_index + CW'(1);
  assign ack_level = (byte_index >= held_count);

  // buffer ports: loads at the fill pointer, reads follow the byte index
  assign buf_wr_en   = step && (phase == PH_IDLE) && (req_type == REQ_LOAD)
                       && (32'(load_pointer) < 32'(MAX_BURST));
  assign buf_wr_addr = load_pointer[AW-1:0];
  assign buf_rd_addr = byte_index[AW-1:0];

  // segment kind of each phase
  always_comb begin
    case (phase)
      PH_ADDR_STOP, PH_END_STOP:                        seg = SEG_STOP;
      PH_ADDR_START, PH_RS_START:                       seg = SEG_START;
      PH_ADDR_BYTE, PH_REG_BYTE, PH_RADDR_BYTE,
      PH_WDATA_BYTE:                                    seg = SEG_WBYTE;
      PH_RDATA_BYTE:                                    seg = SEG_RBYTE;
      PH_ADDR_ACK, PH_REG_ACK, PH_RADDR_ACK,
      PH_WDATA_ACK:                                     seg = SEG_RACK;
      PH_RDATA_ACK:                                     seg = SEG_WACK;
      default:                                          seg = SEG_NONE;
    endcase
  end

  // one pin action, then the phase transition
  always_comb begin
    phase_next         = phase;
    micro_next         = micro;
    bit_counter_next   = bit_counter;
    byte_index_next    = byte_index;
    retry_counter_next = retry_counter;
    wait_counter_next  = wait_counter;
    shift_reg_next     = shift_reg;
    held_dev_addr_next = held_dev_addr;
    held_reg_addr_next = held_reg_addr;
    held_count_next    = held_count;
    read_mode_next     = read_mode;
    load_pointer_next  = load_pointer;
    nack_flag_next     = nack_flag;
    pin_scl_next       = pin_scl;
    pin_sda_next       = pin_sda;
    pin_oe_next        = pin_oe;
    seg_done           = 1'b0;
    res                = '0;

    // segment micro steps
    case (seg)
      SEG_STOP: begin
        micro_next = micro + 3'd1;
        case (micro)
          3'd0: pin_sda_next = 1'b0;
          3'd1: pin_oe_next = 1'b1;
          3'd2: pin_scl_next = 1'b1;
          default: begin
            pin_sda_next = 1'b1;
            micro_next = 3'd0;
            seg_done = 1'b1;
          end
        endcase
      end
      SEG_START: begin
        micro_next = micro + 3'd1;
        case (micro)
          3'd0: pin_scl_next = 1'b1;
          3'd1: pin_sda_next = 1'b1;
          3'd2: pin_oe_next = 1'b1;
          3'd3: pin_sda_next = 1'b0;
          default: begin
            pin_scl_next = 1'b0;
            micro_next = 3'd0;
            seg_done = 1'b1;
          end
        endcase
      end
      SEG_WBYTE: begin
        case (micro)
          3'd0: begin
            pin_scl_next = 1'b0;
            micro_next = 3'd1;
          end
          3'd1: begin
            pin_oe_next = 1'b1;
            bit_counter_next = 4'd0;
            micro_next = 3'd2;
            // buffer read data has settled by now
            if (phase == PH_WDATA_BYTE) begin
              shift_reg_next = buf_rd_data;
            end
          end
          3'd2: begin
            pin_sda_next = shift_reg[7];
            micro_next = 3'd3;
          end
          3'd3: begin
            pin_scl_next = 1'b1;
            micro_next = 3'd4;
          end
          default: begin
            pin_scl_next = 1'b0;
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bit_counter_next = bc_inc;
            if (bc_inc >= 4'd8) begin
              micro_next = 3'd0;
              seg_done = 1'b1;
            end else begin
              micro_next = 3'd2;
            end
          end
        endcase
      end
      SEG_RBYTE: begin
        case (micro)
          3'd0: begin
            pin_scl_next = 1'b0;
            micro_next = 3'd1;
          end
          3'd1: begin
            pin_oe_next = 1'b0;
            bit_counter_next = 4'd0;
            micro_next = 3'd2;
          end
          3'd2: begin
            pin_scl_next = 1'b1;
            micro_next = 3'd3;
          end
          default: begin
            pin_scl_next = 1'b0;
            shift_reg_next = {shift_reg[6:0], sda_in};
            bit_counter_next = bc_inc;
            if (bc_inc >= 4'd8) begin
              micro_next = 3'd0;
              seg_done = 1'b1;
            end else begin
              micro_next = 3'd2;
            end
          end
        endcase
      end
      SEG_RACK: begin
        case (micro)
          3'd0: begin
            pin_scl_next = 1'b0;
            micro_next = 3'd1;
          end
          3'd1: begin
            pin_oe_next = 1'b0;
            wait_counter_next = 8'd0;
            nack_flag_next = 1'b0;
            micro_next = 3'd2;
          end
          3'd2: begin
            pin_scl_next = 1'b1;
            micro_next = 3'd3;
          end
          3'd3: begin
            if (!sda_in) begin
              micro_next = 3'd4;
            end else if (wait_counter >= ack_wait_limit) begin
              nack_flag_next = 1'b1;
              micro_next = 3'd4;
            end else begin
              wait_counter_next = wait_counter + 8'd1;
            end
          end
          default: begin
            pin_scl_next = 1'b0;
            micro_next = 3'd0;
            seg_done = 1'b1;
          end
        endcase
      end
      SEG_WACK: begin
        micro_next = micro + 3'd1;
        case (micro)
          3'd0: pin_sda_next = ack_level;
          3'd1: pin_oe_next = 1'b1;
          3'd2: pin_scl_next = 1'b1;
          default: begin
            pin_scl_next = 1'b0;
            micro_next = 3'd0;
            seg_done = 1'b1;
          end
        endcase
      end
      default: ;
    endcase

    // phase transitions
    case (phase)
      PH_IDLE: begin
        if (req_type == REQ_LOAD) begin
          if (32'(load_pointer) < 32'(MAX_BURST)) begin
            load_pointer_next = load_pointer + CW'(1);
          end
        end else if (req_type == REQ_WRITE || req_type == REQ_READ) begin
          held_dev_addr_next = dev_addr;
          held_reg_addr_next = reg_addr;
          held_count_next = (32'(byte_count) > 32'(MAX_BURST)) ? CW'(MAX_BURST)
                                                                : CW'(byte_count);
          read_mode_next = (req_type == REQ_READ);
          retry_counter_next = 4'd0;
          byte_index_next = '0;
          micro_next = 3'd0;
          load_pointer_next = '0;
          phase_next = PH_ADDR_STOP;
        end
      end
      PH_ADDR_STOP: if (seg_done) phase_next = PH_ADDR_START;
      PH_ADDR_START: begin
        if (seg_done) begin
          shift_reg_next = {held_dev_addr[7:1], 1'b0};
          phase_next = PH_ADDR_BYTE;
        end
      end
      PH_ADDR_BYTE: begin
        if (seg_done) begin
          if (retry_counter >= addr_retry_limit) begin
            res.done_res = 1'b1;
            res.status = ST_RETRY;
            phase_next = PH_IDLE;
          end else begin
            retry_counter_next = retry_counter + 4'd1;
            phase_next = PH_ADDR_ACK;
          end
        end
      end
      PH_ADDR_ACK: begin
        if (seg_done) begin
          if (nack_flag_next) begin
            phase_next = PH_ADDR_STOP;
          end else begin
            shift_reg_next = held_reg_addr;
            phase_next = PH_REG_BYTE;
          end
        end
      end
      PH_REG_BYTE: if (seg_done) phase_next = PH_REG_ACK;
      PH_REG_ACK: begin
        if (seg_done) begin
          if (nack_flag_next) begin
            res.done_res = 1'b1;
            res.status = ST_REG_NACK;
            phase_next = PH_IDLE;
          end else if (read_mode) begin
            phase_next = PH_RS_START;
          end else if (held_count == '0) begin
            phase_next = PH_END_STOP;
          end else begin
            byte_index_next = '0;
            phase_next = PH_WDATA_BYTE;
          end
        end
      end
      PH_RS_START: begin
        if (seg_done) begin
          shift_reg_next = {held_dev_addr[7:1], 1'b1};
          phase_next = PH_RADDR_BYTE;
        end
      end
      PH_RADDR_BYTE: if (seg_done) phase_next = PH_RADDR_ACK;
      PH_RADDR_ACK: begin
        if (seg_done) begin
          if (nack_flag_next) begin
            res.done_res = 1'b1;
            res.status = ST_RADR_NACK;
            phase_next = PH_IDLE;
          end else begin
            byte_index_next = '0;
            phase_next = (held_count == '0) ? PH_RDATA_ACK : PH_RDATA_BYTE;
          end
        end
      end
      PH_WDATA_BYTE: if (seg_done) phase_next = PH_WDATA_ACK;
      PH_WDATA_ACK: begin
        if (seg_done) begin
          if (nack_flag_next) begin
            res.done_res = 1'b1;
            res.status = ST_DATA_NACK;
            phase_next = PH_IDLE;
          end else begin
            byte_index_next = bi_inc;
            phase_next = (bi_inc < held_count) ? PH_WDATA_BYTE : PH_END_STOP;
          end
        end
      end
      PH_RDATA_BYTE: begin
        if (seg_done) begin
          res.rd_valid = 1'b1;
          res.rd_data = shift_reg_next;
          byte_index_next = bi_inc;
          phase_next = PH_RDATA_ACK;
        end
      end
      PH_RDATA_ACK: begin
        if (seg_done) begin
          phase_next = (byte_index < held_count) ? PH_RDATA_BYTE : PH_END_STOP;
        end
      end
      PH_END_STOP: begin
        if (seg_done) begin
          res.done_res = 1'b1;
          res.status = ST_OK;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        micro_next = 3'd0;
      end
    endcase

    res.scl = pin_scl_next;
    res.sda_out = pin_sda_next;
    res.sda_oe = pin_oe_next;
    res.busy_res = (phase_next != PH_IDLE);
  end

  // state update, one tick per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      micro         <= 3'd0;
      bit_counter   <= 4'd0;
      byte_index    <= '0;
      retry_counter <= 4'd0;
      wait_counter  <= 8'd0;
      shift_reg     <= 8'd0;
      held_dev_addr <= 8'd0;
      held_reg_addr <= 8'd0;
      held_count    <= '0;
      read_mode     <= 1'b0;
      load_pointer  <= '0;
      nack_flag     <= 1'b0;
      pin_scl       <= 1'b1;
      pin_sda       <= 1'b1;
      pin_oe        <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      micro         <= micro_next;
      bit_counter   <= bit_counter_next;
      byte_index    <= byte_index_next;
      retry_counter <= retry_counter_next;
      wait_counter  <= wait_counter_next;
      shift_reg     <= shift_reg_next;
      held_dev_addr <= held_dev_addr_next;
      held_reg_addr <= held_reg_addr_next;
      held_count    <= held_count_next;
      read_mode     <= read_mode_next;
      load_pointer  <= load_pointer_next;
      nack_flag     <= nack_flag_next;
      pin_scl       <= pin_scl_next;
      pin_sda       <= pin_sda_next;
      pin_oe        <= pin_oe_next;
    end
  end

endmodule
`default_nettype wire

@@ design/i2c_master_register_access_top.sv @@
`default_nettype none
// Pin-level I2C master for register reads and writes. Each input transaction
// is one bus tick (tuser carries the command, tdata the operands and the
// sampled SDA level) and yields exactly one output transaction with the pin
// levels, busy, any read byte and the done status. The result of a tick sits
// in the output register from the cycle after the tick is accepted. A tick is
// taken every clock cycle while results are being taken; a waiting result
// holds off the input, and the next tick enters in the same cycle in which
// that result is taken. The write buffer's registered read port is addressed
// before its byte is loaded for shifting, so it adds no stall. Write bytes are
// preloaded into a MAX_BURST-entry buffer while idle; commands arriving
// while a transfer is running are dropped. Limits for address retries and
// ACK polling sit at APB offsets 0x0 and 0x4 and may be changed only while
// the block is idle.
`include "i2c_master_register_access_top_macros.svh"
module i2c_master_register_access_top import i2cm_pkg::*; #(
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // dev_addr[7:0], reg_addr[15:8], byte_count[20:16], wr_data[28:21], sda_in[29]
  input  wire logic [31:0] s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // scl[0], sda_out[1], sda_oe[2], busy_res[3], rd_data[11:4], done_res[12],
  // status[15:13]
  output logic      [15:0] m_tdata,
  // rd_valid[0]
  output logic             m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

  logic [3:0]    addr_retry_limit;
  logic [7:0]    ack_wait_limit;
  logic          step;
  res_t          res;
  res_t          out_q;
  logic          buf_wr_en;
  logic [AW-1:0] buf_wr_addr;
  logic [AW-1:0] buf_rd_addr;
  logic [7:0]    buf_rd_data;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_retry_limit <= RETRY_RESET;
      ack_wait_limit   <= ACK_WAIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_RETRY: addr_retry_limit <= pwdata[3:0];
        REG_WAIT:  ack_wait_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RETRY: prdata = {28'd0, addr_retry_limit};
      REG_WAIT:  prdata = {24'd0, ack_wait_limit};
      default:   prdata = 32'd0;
    endcase
  end

  // input acceptance follows free space in the output register
  assign s_tready = !m_tvalid || m_tready;
  assign step = s_tvalid && s_tready;

  i2cm_wbuf #(.MAX_BURST(MAX_BURST)) u_wbuf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (buf_wr_addr),
    .wr_data (s_tdata[28:21]),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  i2cm_engine #(.MAX_BURST(MAX_BURST)) u_engine (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .req_type         (s_tuser),
    .dev_addr         (s_tdata[7:0]),
    .reg_addr         (s_tdata[15:8]),
    .byte_count       (s_tdata[20:16]),
    .sda_in           (s_tdata[29]),
    .addr_retry_limit (addr_retry_limit),
    .ack_wait_limit   (ack_wait_limit),
    .buf_rd_data      (buf_rd_data),
    .buf_wr_en        (buf_wr_en),
    .buf_wr_addr      (buf_wr_addr),
    .buf_rd_addr      (buf_rd_addr),
    .res              (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_tdata = {out_q.status, out_q.done_res, out_q.rd_data, out_q.busy_res,
                    out_q.sda_oe, out_q.sda_out, out_q.scl};
  assign m_tuser = out_q.rd_valid;

  // checks on the result stream
  `I2CM_ASSERT_IMP(a_done_not_busy, m_tvalid && out_q.done_res, !out_q.busy_res, "done while busy")
  `I2CM_ASSERT_IMP(a_read_busy, m_tvalid && out_q.rd_valid, out_q.busy_res, "read byte while idle")
  `I2CM_ASSERT_IMP(a_status_done, m_tvalid && out_q.status != ST_OK, out_q.done_res, "status without done")
  `I2CM_ASSERT(a_step_fills, step |=> m_tvalid, "accepted tick lost")

endmodule
`default_nettype wire

@@ sim/i2c_master_register_access_top_tb.sv @@
`timescale 1ns / 1ps
module i2c_master_register_access_top_tb;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BUF_DEPTH = MAX_BURST_DEF;

  typedef enum logic [4:0] {
    P_IDLE, P_ADDR_STOP, P_ADDR_START, P_ADDR_BYTE, P_ADDR_ACK, P_REG_BYTE,
    P_REG_ACK, P_RS_START, P_RADDR_BYTE, P_RADDR_ACK, P_WDATA_BYTE,
    P_WDATA_ACK, P_RDATA_BYTE, P_RDATA_ACK, P_END_STOP
  } phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = REQ_IDLE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_register_access_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // bus master model state
  phase_e     bus_phase;
  logic [3:0] bit_cnt, retry_cnt, retry_lim;
  logic [4:0] byte_idx, burst_len, load_ptr;
  logic [7:0] wait_cnt, wait_lim, shifter, dev_hold, reg_hold;
  logic       is_read, nack_seen, pin_scl, pin_sda, pin_oe;
  logic [7:0] wr_buf [BUF_DEPTH];
  int         micro;

  res_t tick_results[$];
  int   send_idle_pct, recv_stall_pct;
  int   ticks_sent, mismatches, errors, cycles;
  int   status_seen [5];
  int   bytes_read;

  // segment helpers, each one pin action per tick
  function automatic bit stop_seg();
    case (micro)
      0: pin_sda = 0;
      1: pin_oe = 1;
      2: pin_scl = 1;
      default: begin
        pin_sda = 1; micro = 0; return 1;
      end
    endcase
    micro++;
    return 0;
  endfunction

  function automatic bit start_seg();
    case (micro)
      0: pin_scl = 1;
      1: pin_sda = 1;
      2: pin_oe = 1;
      3: pin_sda = 0;
      default: begin
        pin_scl = 0; micro = 0; return 1;
      end
    endcase
    micro++;
    return 0;
  endfunction

  function automatic bit send_byte_seg();
    case (micro)
      0: begin pin_scl = 0; micro = 1; end
      1: begin pin_oe = 1; bit_cnt = 0; micro = 2; end
      2: begin pin_sda = shifter[7]; micro = 3; end
      3: begin pin_scl = 1; micro = 4; end
      default: begin
        pin_scl = 0;
        shifter = shifter << 1;
        bit_cnt = bit_cnt + 1;
        if (bit_cnt >= 8) begin
          micro = 0; return 1;
        end
        micro = 2;
      end
    endcase
    return 0;
  endfunction

  function automatic bit recv_byte_seg(logic sda);
    case (micro)
      0: begin pin_scl = 0; micro = 1; end
      1: begin pin_oe = 0; bit_cnt = 0; micro = 2; end
      2: begin pin_scl = 1; micro = 3; end
      default: begin
        pin_scl = 0;
        shifter = {shifter[6:0], sda};
        bit_cnt = bit_cnt + 1;
        if (bit_cnt >= 8) begin
          micro = 0; return 1;
        end
        micro = 2;
      end
    endcase
    return 0;
  endfunction

  // ack poll, nack_seen set when the slave never pulls sda low
  function automatic bit poll_ack_seg(logic sda);
    case (micro)
      0: begin pin_scl = 0; micro = 1; end
      1: begin pin_oe = 0; wait_cnt = 0; nack_seen = 0; micro = 2; end
      2: begin pin_scl = 1; micro = 3; end
      3: begin
        if (!sda) micro = 4;
        else if (wait_cnt >= wait_lim) begin
          nack_seen = 1; micro = 4;
        end else wait_cnt = wait_cnt + 1;
      end
      default: begin
        pin_scl = 0; micro = 0; return 1;
      end
    endcase
    return 0;
  endfunction

  function automatic bit give_ack_seg(logic level);
    case (micro)
      0: pin_sda = level;
      1: pin_oe = 1;
      2: pin_scl = 1;
      default: begin
        pin_scl = 0; micro = 0; return 1;
      end
    endcase
    micro++;
    return 0;
  endfunction

  function automatic logic [7:0] buf_byte(logic [4:0] idx);
    return idx < BUF_DEPTH ? wr_buf[idx] : 8'h00;
  endfunction

  // advance the bus master by one tick and return its pin/status result
  function automatic res_t bus_tick(logic [1:0] req, logic [7:0] dev, logic [7:0] rg,
                                    logic [4:0] cnt, logic [7:0] wd, logic sda);
    res_t r;
    r = '0;
    case (bus_phase)
      P_IDLE: begin
        if (req == REQ_LOAD) begin
          if (load_ptr < BUF_DEPTH) begin
            wr_buf[load_ptr] = wd;
            load_ptr = load_ptr + 1;
          end
        end else if (req == REQ_WRITE || req == REQ_READ) begin
          dev_hold = dev; reg_hold = rg;
          burst_len = cnt > BUF_DEPTH ? 5'(BUF_DEPTH) : cnt;
          is_read = (req == REQ_READ);
          retry_cnt = 0; byte_idx = 0; micro = 0; load_ptr = 0;
          bus_phase = P_ADDR_STOP;
        end
      end
      P_ADDR_STOP: if (stop_seg()) bus_phase = P_ADDR_START;
      P_ADDR_START: if (start_seg()) begin
        shifter = {dev_hold[7:1], 1'b0}; bus_phase = P_ADDR_BYTE;
      end
      P_ADDR_BYTE: if (send_byte_seg()) begin
        if (retry_cnt >= retry_lim) begin
          r.done_res = 1; r.status = ST_RETRY; bus_phase = P_IDLE;
        end else begin
          retry_cnt = retry_cnt + 1; bus_phase = P_ADDR_ACK;
        end
      end
      P_ADDR_ACK: if (poll_ack_seg(sda)) begin
        if (nack_seen) bus_phase = P_ADDR_STOP;
        else begin
          shifter = reg_hold; bus_phase = P_REG_BYTE;
        end
      end
      P_REG_BYTE: if (send_byte_seg()) bus_phase = P_REG_ACK;
      P_REG_ACK: if (poll_ack_seg(sda)) begin
        if (nack_seen) begin
          r.done_res = 1; r.status = ST_REG_NACK; bus_phase = P_IDLE;
        end else if (is_read) bus_phase = P_RS_START;
        else if (burst_len == 0) bus_phase = P_END_STOP;
        else begin
          byte_idx = 0; shifter = buf_byte(0); bus_phase = P_WDATA_BYTE;
        end
      end
      P_RS_START: if (start_seg()) begin
        shifter = {dev_hold[7:1], 1'b1}; bus_phase = P_RADDR_BYTE;
      end
      P_RADDR_BYTE: if (send_byte_seg()) bus_phase = P_RADDR_ACK;
      P_RADDR_ACK: if (poll_ack_seg(sda)) begin
        if (nack_seen) begin
          r.done_res = 1; r.status = ST_RADR_NACK; bus_phase = P_IDLE;
        end else begin
          byte_idx = 0;
          bus_phase = burst_len == 0 ? P_RDATA_ACK : P_RDATA_BYTE;
        end
      end
      P_WDATA_BYTE: if (send_byte_seg()) bus_phase = P_WDATA_ACK;
      P_WDATA_ACK: if (poll_ack_seg(sda)) begin
        if (nack_seen) begin
          r.done_res = 1; r.status = ST_DATA_NACK; bus_phase = P_IDLE;
        end else begin
          byte_idx = byte_idx + 1;
          if (byte_idx < burst_len) begin
            shifter = buf_byte(byte_idx); bus_phase = P_WDATA_BYTE;
          end else bus_phase = P_END_STOP;
        end
      end
      P_RDATA_BYTE: if (recv_byte_seg(sda)) begin
        r.rd_valid = 1; r.rd_data = shifter;
        byte_idx = byte_idx + 1;
        bus_phase = P_RDATA_ACK;
      end
      P_RDATA_ACK: if (give_ack_seg(byte_idx >= burst_len))
        bus_phase = byte_idx < burst_len ? P_RDATA_BYTE : P_END_STOP;
      P_END_STOP: if (stop_seg()) begin
        r.done_res = 1; r.status = ST_OK; bus_phase = P_IDLE;
      end
      default: begin
        bus_phase = P_IDLE; micro = 0;
      end
    endcase
    r.scl = pin_scl; r.sda_out = pin_sda; r.sda_oe = pin_oe;
    r.busy_res = bus_phase != P_IDLE;
    return r;
  endfunction

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("i2c_master_register_access_top_tb: FAIL");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare every result transaction with the oldest expected tick
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.scl = m_tdata[0]; got.sda_out = m_tdata[1]; got.sda_oe = m_tdata[2];
      got.busy_res = m_tdata[3]; got.rd_data = m_tdata[11:4];
      got.done_res = m_tdata[12]; got.status = m_tdata[15:13];
      got.rd_valid = m_tuser;
      if (tick_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", m_tdata);
      end else begin
        want = tick_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp scl%b sda%b oe%b busy%b rv%b rd%h done%b st%0d",
                     want.scl, want.sda_out, want.sda_oe, want.busy_res, want.rd_valid,
                     want.rd_data, want.done_res, want.status,
                     " / got scl%b sda%b oe%b busy%b rv%b rd%h done%b st%0d",
                     got.scl, got.sda_out, got.sda_oe, got.busy_res, got.rd_valid,
                     got.rd_data, got.done_res, got.status);
        end
        if (want.done_res && want.status <= ST_RADR_NACK) status_seen[want.status]++;
        if (want.rd_valid) bytes_read++;
      end
    end
  end

  // send one tick transaction, with random gaps in front
  task automatic send_tick(logic [1:0] req, logic [7:0] dev, logic [7:0] rg,
                           logic [4:0] cnt, logic [7:0] wd, logic sda);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {2'b00, sda, wd, cnt, rg, dev};
    do @(posedge clk); while (!s_tready);
    tick_results.push_back(bus_tick(req, dev, rg, cnt, wd, sda));
    ticks_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tick_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic reg_sel, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= wr;
    paddr <= {reg_sel, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== data) begin
      errors++;
      $display("register %0d read %h, expected %h", reg_sel, prdata, data);
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // program both limits while idle and read them back
  task automatic set_limits(logic [3:0] retries, logic [7:0] waits);
    wait_drained();
    apb_access(1'b1, REG_RETRY, {28'd0, retries});
    apb_access(1'b1, REG_WAIT, {24'd0, waits});
    retry_lim = retries; wait_lim = waits;
    apb_access(1'b0, REG_RETRY, {28'd0, retries});
    apb_access(1'b0, REG_WAIT, {24'd0, waits});
  endtask

  // one burst with preloaded bytes; sda high with the given percentage
  task automatic run_burst(logic [1:0] kind, logic [4:0] cnt, int loads, int high_pct);
    for (int i = 0; i < loads; i++)
      send_tick(REQ_LOAD, 8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom),
                1'($urandom));
    send_tick(kind, 8'($urandom), 8'($urandom), cnt, 8'($urandom), 1'($urandom));
    while (bus_phase != P_IDLE) begin
      // stray commands while busy must be dropped
      if ($urandom_range(99) < 8)
        send_tick(2'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom),
                  $urandom_range(99) < high_pct);
      else
        send_tick(REQ_IDLE, 8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom),
                  $urandom_range(99) < high_pct);
    end
  endtask

  task automatic test_directed_write();
    // fill the buffer, the extra loads hit a full buffer, oversized count
    run_burst(REQ_WRITE, 5'd31, 18, 0);
    run_burst(REQ_WRITE, 5'd0, 0, 0);
    send_tick(REQ_LOAD, 8'h00, 8'h00, 5'd0, 8'hff, 1'b1);
    run_burst(REQ_WRITE, 5'd1, 0, 0);
  endtask

  task automatic test_directed_read();
    send_tick(REQ_IDLE, 8'hff, 8'hff, 5'd31, 8'hff, 1'b1);
    run_burst(REQ_READ, 5'd0, 0, 0);
    run_burst(REQ_READ, 5'd3, 0, 30);
  endtask

  task automatic test_nack_paths();
    set_limits(4'd2, 8'd0);
    run_burst(REQ_WRITE, 5'd3, 0, 100);
    set_limits(4'd0, 8'd3);
    run_burst(REQ_READ, 5'd3, 0, 100);
    set_limits(4'd15, 8'd2);
    run_burst(REQ_WRITE, 5'd4, 0, 60);
    set_limits(RETRY_RESET, ACK_WAIT_RESET);
  endtask

  task automatic test_random(int count);
    int bursts;
    int target;
    bursts = 0;
    target = ticks_sent + count;
    while (ticks_sent < target) begin
      if (bursts % 3 == 1)
        set_limits(4'($urandom_range(0, 15)),
                   8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                : $urandom_range(0, 4)));
      if ($urandom_range(9) == 0) wait_drained();
      if ($urandom_range(9) < 2)
        repeat ($urandom_range(1, 4))
          send_tick(2'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 5'($urandom),
                    8'($urandom), 1'($urandom));
      run_burst(2'($urandom_range(2, 3)),
                5'($urandom_range(9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 4)),
                $urandom_range(0, 5), $urandom_range(9) < 7 ? 10 : $urandom_range(0, 100));
      bursts++;
    end
    $display("random bursts: %0d", bursts);
  endtask

  initial begin
    bus_phase = P_IDLE; bit_cnt = 0; byte_idx = 0; retry_cnt = 0; wait_cnt = 0;
    shifter = 0; dev_hold = 0; reg_hold = 0; burst_len = 0; is_read = 0; load_ptr = 0;
    micro = 0; nack_seen = 0; pin_scl = 1; pin_sda = 1; pin_oe = 0;
    retry_lim = RETRY_RESET; wait_lim = ACK_WAIT_RESET;
    foreach (wr_buf[i]) wr_buf[i] = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    ticks_sent = 0; mismatches = 0; errors = 0; cycles = 0; bytes_read = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no idling
    test_directed_write();
    // sender idle
    send_idle_pct = 47; recv_stall_pct = 0;
    test_directed_read();
    // receiver stalling
    send_idle_pct = 0; recv_stall_pct = 47;
    test_nack_paths();
    // both idle now and then
    send_idle_pct = 7; recv_stall_pct = 7;
    test_random(450);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("ticks %0d, bytes read %0d, done ok/retry/reg/data/raddr %0d/%0d/%0d/%0d/%0d",
             ticks_sent, bytes_read, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4]);
    $display("mismatches %0d, other errors %0d", mismatches, errors);
    if (mismatches == 0 && errors == 0 && tick_results.size() == 0) begin
      $display("i2c_master_register_access_top_tb: PASS");
    end else begin
      $display("i2c_master_register_access_top_tb: FAIL");
    end
    $finish;
  end

endmodule
